@@ rtl/core/mmbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mmbp_pkg
// Shared constants and types for the masked message bit packer.
// ----------------------------------------------------------------------------
package mmbp_pkg;

  // Packed word size and derived widths
  localparam int WordBits  = 64;
  localparam int FillW     = $clog2(WordBits);      // width of the partial-word fill count
  localparam int WidthW    = FillW + 1;             // bit width 0..127 as written

  // Reset value of the bit width register
  localparam logic [WidthW-1:0] WidthReset = WidthW'(WordBits);

  // One masked message on its way from the front end to the packer
  typedef struct packed {
    logic [WordBits-1:0] value;   // XORed and masked message
    logic [WidthW-1:0]   width;   // effective width, 1..64
    logic                last;    // final message of the stream
  } item_t;

  // Packer status seen by the top level
  typedef struct packed {
    logic             pend_valid; // flush word waits behind the output register
    logic [FillW-1:0] fill;       // valid bits in the partial word
  } back_status_t;

endpackage

@@ rtl/core/mmbp_msg_if.sv @@
// ----------------------------------------------------------------------------
// mmbp_msg_if
// Message channel: one message with its pad per transaction.
// ----------------------------------------------------------------------------
interface mmbp_msg_if;
  logic                          valid;
  logic                          ready;
  logic [mmbp_pkg::WordBits-1:0] message_value;
  logic [mmbp_pkg::WordBits-1:0] pad_word;
  logic                          last_message;

  modport source (output valid, output message_value, output pad_word,
                  output last_message, input ready);
  modport sink   (input valid, input message_value, input pad_word,
                  input last_message, output ready);
endinterface

@@ rtl/core/mmbp_word_if.sv @@
// ----------------------------------------------------------------------------
// mmbp_word_if
// Word channel: one packed 64-bit word per transaction.
// ----------------------------------------------------------------------------
interface mmbp_word_if;
  logic                          valid;
  logic                          ready;
  logic [mmbp_pkg::WordBits-1:0] packed_word;
  logic                          last_word;

  modport source (output valid, output packed_word, output last_word, input ready);
  modport sink   (input valid, input packed_word, input last_word, output ready);
endinterface

@@ rtl/core/mmbp_front.sv @@
// ----------------------------------------------------------------------------
// mmbp_front
// Front end: holds the width register, XORs and masks each message and
// registers the result for the queue.
// ----------------------------------------------------------------------------
module mmbp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mmbp_pkg::WidthW-1:0]   cfg_wdata_i,
  mmbp_msg_if.sink                      in_if,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output mmbp_pkg::item_t               item_o
);

  logic [mmbp_pkg::WidthW-1:0]   width_q;
  logic [mmbp_pkg::WidthW-1:0]   eff_width;
  logic [mmbp_pkg::WordBits-1:0] mask;
  logic                          stg_valid_q, stg_valid_d;
  mmbp_pkg::item_t               stg_q, stg_d;
  logic                          in_take;

  // Width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= mmbp_pkg::WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // Zero counts as one, anything past a full word saturates
  always_comb begin
    if (width_q == '0) begin
      eff_width = mmbp_pkg::WidthW'(1);
    end else if (width_q > mmbp_pkg::WidthW'(mmbp_pkg::WordBits)) begin
      eff_width = mmbp_pkg::WidthW'(mmbp_pkg::WordBits);
    end else begin
      eff_width = width_q;
    end
  end

  assign mask = {mmbp_pkg::WordBits{1'b1}} >>
                (mmbp_pkg::WidthW'(mmbp_pkg::WordBits) - eff_width);

  // Stage register, refilled whenever it empties toward the queue
  assign in_take     = in_if.valid && in_if.ready;
  assign in_if.ready = !stg_valid_q || item_ready_i;

  always_comb begin
    stg_valid_d = stg_valid_q;
    stg_d       = stg_q;
    if (item_ready_i) begin
      stg_valid_d = 1'b0;
    end
    if (in_take) begin
      stg_valid_d = 1'b1;
      stg_d.value = (in_if.message_value ^ in_if.pad_word) & mask;
      stg_d.width = eff_width;
      stg_d.last  = in_if.last_message;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign item_valid_o = stg_valid_q;
  assign item_o       = stg_q;

endmodule

@@ rtl/core/mmbp_queue.sv @@
// ----------------------------------------------------------------------------
// mmbp_queue
// Two-entry queue between front end and packer.
// ----------------------------------------------------------------------------
module mmbp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  mmbp_pkg::item_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output mmbp_pkg::item_t pop_data_o
);

  mmbp_pkg::item_t slot_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/mmbp_back.sv @@
// ----------------------------------------------------------------------------
// mmbp_back
// Packer: appends masked messages to the partial word, emits full words and
// flush words through an output register with one pending slot behind it.
// ----------------------------------------------------------------------------
module mmbp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  mmbp_pkg::item_t        item_i,
  mmbp_word_if.source            out_if,
  output mmbp_pkg::back_status_t status_o
);

  localparam int WB = mmbp_pkg::WordBits;
  localparam int FW = mmbp_pkg::FillW;
  localparam int WW = mmbp_pkg::WidthW;

  logic [WB-1:0] partial_q, partial_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          out_valid_q, out_valid_d;
  logic [WB-1:0] out_word_q, out_word_d;
  logic          out_last_q, out_last_d;
  logic          pend_valid_q, pend_valid_d;
  logic [WB-1:0] pend_word_q, pend_word_d;

  logic          slot_free, take;
  logic [WW-1:0] total;
  logic [WB-1:0] word;
  logic          full;
  logic [FW-1:0] rest;
  logic [WB-1:0] next_partial;
  logic [FW-1:0] next_fill;
  logic          flush;

  assign slot_free    = !out_valid_q || out_if.ready;
  assign item_ready_o = slot_free && !pend_valid_q;
  assign take         = item_valid_i && item_ready_o;

  // Append the new value behind the bits already held
  assign total = WW'(fill_q) + item_i.width;
  assign word  = partial_q | (item_i.value << fill_q);
  assign full  = total[WW-1];
  assign rest  = total[FW-1:0];

  always_comb begin
    if (full) begin
      next_partial = (rest == '0) ? '0 : (item_i.value >> (WW'(WB) - WW'(fill_q)));
      next_fill    = rest;
    end else begin
      next_partial = word;
      next_fill    = total[FW-1:0];
    end
    flush = item_i.last && (next_fill != '0);
  end

  // Packing state and result registers
  always_comb begin
    partial_d    = partial_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    pend_valid_d = pend_valid_q;
    pend_word_d  = pend_word_q;
    if (slot_free) begin
      out_valid_d = 1'b0;
    end
    if (pend_valid_q && slot_free) begin
      // second result of a spilling last message
      out_valid_d  = 1'b1;
      out_word_d   = pend_word_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
    if (take) begin
      partial_d = item_i.last ? '0 : next_partial;
      fill_d    = item_i.last ? '0 : next_fill;
      if (full) begin
        out_valid_d  = 1'b1;
        out_word_d   = word;
        out_last_d   = item_i.last && (rest == '0);
        pend_valid_d = flush;
        pend_word_d  = next_partial;
      end else if (flush) begin
        out_valid_d = 1'b1;
        out_word_d  = next_partial;
        out_last_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q    <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      partial_q    <= partial_d;
      fill_q       <= fill_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    out_last_q  <= out_last_d;
    pend_word_q <= pend_word_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.packed_word = out_word_q;
  assign out_if.last_word   = out_last_q;

  assign status_o.pend_valid = pend_valid_q;
  assign status_o.fill       = fill_q;

endmodule

@@ rtl/core/masked_message_bit_packer.sv @@
// ----------------------------------------------------------------------------
// masked_message_bit_packer
// XORs each message with its pad, masks it to the configured width and packs
// the results LSB first into 64-bit words.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_if     in   valid/ready        message_value, pad_word, last_message
//  out_if    out  valid/ready        packed_word, last_word
//  cfg       in   cfg_we_i           cfg_wdata_i (bit_width, 7 bits)
//
// One message per cycle is accepted while neither side stalls. The message
// that completes a word passes the front stage, queue and output register.
// A last message that fills a word and spills over gives two words; the
// packer takes no message while the second waits in the pending slot, which
// the queue absorbs, and the input stalls only once the queue has filled.
// Reset clears the partial word and sets bit_width to 64.
// Either side may stall at any time; the queue lets front and packer stall
// independently.
// ----------------------------------------------------------------------------
module masked_message_bit_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mmbp_pkg::WidthW-1:0] cfg_wdata_i,
  mmbp_msg_if.sink                    in_if,
  mmbp_word_if.source                 out_if
);

  logic                   f_valid, f_ready;
  mmbp_pkg::item_t        f_item;
  logic                   q_valid, q_ready;
  mmbp_pkg::item_t        q_item;
  mmbp_pkg::back_status_t b_status;

  mmbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_if        (in_if),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  mmbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_item)
  );

  mmbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_if       (out_if),
    .status_o     (b_status)
  );

`ifndef SYNTHESIS
  // A pending flush word always sits behind a valid output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.pend_valid |-> out_if.valid)
    else $error("pending flush word without a valid output word");

  // The last message of a stream leaves the packer empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready && q_item.last) |=> (b_status.fill == '0))
    else $error("partial word not cleared after last message");

  // Packer takes no transaction while a flush word is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.pend_valid |-> !q_ready)
    else $error("packer accepted a message with a flush word pending");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for masked_message_bit_packer. A bit-level predictor
// keeps its own partial word and fill count, turns every accepted message
// transaction into the packed words it should produce, and the word monitor
// compares each output transaction against the oldest prediction. Stimulus
// covers width extremes, out-of-range widths, exact and spilling flushes,
// random streams with and without pad, random idling on both channels and a
// long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SETTLE_CYCLES = 8;     // outlasts the front, queue and output reg drain
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transaction
  localparam int unsigned HOLD_CYCLES   = 200;   // long output hold-off

  typedef struct packed {
    logic [mmbp_pkg::WordBits-1:0] word;
    logic                          last;
  } packed_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                        cfg_we_i;
  logic [mmbp_pkg::WidthW-1:0] cfg_wdata_i;

  mmbp_msg_if  msg_if ();
  mmbp_word_if word_if ();

  masked_message_bit_packer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (msg_if),
    .out_if      (word_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state and expected words
  logic [mmbp_pkg::WidthW-1:0]   width_reg;
  logic [mmbp_pkg::WordBits-1:0] partial_acc;
  int unsigned                   fill_cnt;
  packed_word_t                  word_exp_q[$];

  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned hold_len;
  bit          send_idle;
  bit          recv_idle;

  // Append one masked message to the predicted stream
  function automatic void predict_words(input logic [mmbp_pkg::WordBits-1:0] msg,
                                        input logic [mmbp_pkg::WordBits-1:0] pad,
                                        input logic last);
    int unsigned                   w;
    int unsigned                   total;
    logic [mmbp_pkg::WordBits-1:0] v;
    logic [mmbp_pkg::WordBits-1:0] word;
    packed_word_t                  entry;
    if (width_reg == '0) w = 1;
    else if (width_reg > mmbp_pkg::WordBits) w = mmbp_pkg::WordBits;
    else w = 32'(width_reg);
    v = msg ^ pad;
    if (w < mmbp_pkg::WordBits) v = v & ((64'd1 << w) - 64'd1);
    total = fill_cnt + w;
    word  = partial_acc | (v << fill_cnt);
    if (total >= mmbp_pkg::WordBits) begin
      entry.word = word;
      entry.last = last && (total == mmbp_pkg::WordBits);
      word_exp_q.push_back(entry);
      partial_acc = (total == mmbp_pkg::WordBits) ? '0 :
                    (v >> (mmbp_pkg::WordBits - fill_cnt));
      fill_cnt    = total - mmbp_pkg::WordBits;
    end else begin
      partial_acc = word;
      fill_cnt    = total;
    end
    // Last message flushes whatever is left
    if (last) begin
      if (fill_cnt != 0) begin
        entry.word = partial_acc;
        entry.last = 1'b1;
        word_exp_q.push_back(entry);
      end
      partial_acc = '0;
      fill_cnt    = 0;
    end
  endfunction

  function automatic logic [mmbp_pkg::WordBits-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Prediction, word check and stall watchdog
  always @(posedge clk_i) begin
    packed_word_t exp_word;
    if (rst_ni && msg_if.valid && msg_if.ready)
      predict_words(msg_if.message_value, msg_if.pad_word, msg_if.last_message);
    if (rst_ni && word_if.valid && word_if.ready) begin
      if (word_exp_q.size() == 0) begin
        $error("unexpected word transaction: packed_word %h last_word %b",
               word_if.packed_word, word_if.last_word);
        errors++;
      end else begin
        exp_word = word_exp_q.pop_front();
        if (word_if.packed_word !== exp_word.word) begin
          $error("packed_word: expected %h, actual %h", exp_word.word, word_if.packed_word);
          errors++;
        end
        if (word_if.last_word !== exp_word.last) begin
          $error("last_word: expected %b, actual %b", exp_word.last, word_if.last_word);
          errors++;
        end
      end
    end
    if ((msg_if.valid && msg_if.ready) || (word_if.valid && word_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Word sink: random stalls plus an optional long hold-off
  initial begin : word_sink
    int unsigned stall;
    word_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_len != 0) begin
        word_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      stall = recv_idle ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        word_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      word_if.ready <= 1'b1;
      do @(posedge clk_i); while (!word_if.valid);
    end
  end

  // Offer one message transaction and wait until it is taken
  task automatic send_msg(input logic [mmbp_pkg::WordBits-1:0] msg,
                          input logic [mmbp_pkg::WordBits-1:0] pad,
                          input logic last);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    msg_if.valid         <= 1'b1;
    msg_if.message_value <= msg;
    msg_if.pad_word      <= pad;
    msg_if.last_message  <= last;
    do @(posedge clk_i); while (!msg_if.ready);
  endtask

  // One edge first so the predictor has seen the last accepted message
  task automatic wait_words_done();
    @(posedge clk_i);
    while (word_exp_q.size() != 0) @(posedge clk_i);
  endtask

  // Register write only once the block has gone quiet
  task automatic write_bit_width(input int unsigned value);
    msg_if.valid <= 1'b0;
    wait_words_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mmbp_pkg::WidthW'(value);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    width_reg = mmbp_pkg::WidthW'(value);
  endtask

  // Width extremes, out-of-range widths and the flush corner cases
  task automatic test_directed();
    logic [mmbp_pkg::WordBits-1:0] m;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    // reset width of 64: all-ones, pad-only, cancelling pad, exact fill on last
    send_msg('1, '0, 1'b0);
    send_msg('0, '1, 1'b0);
    m = rand_word();
    send_msg(m, m, 1'b0);
    send_msg(rand_word(), rand_word(), 1'b1);
    // single-bit fields, short flush
    write_bit_width(1);
    send_msg(64'd1, '0, 1'b0);
    send_msg('0, '0, 1'b0);
    send_msg('1, '0, 1'b0);
    send_msg('1, 64'd1, 1'b1);
    // zero width behaves as one bit
    write_bit_width(0);
    send_msg(64'd3, '0, 1'b0);
    send_msg(64'd2, '0, 1'b1);
    // widths above 64 saturate
    write_bit_width(127);
    send_msg(rand_word(), rand_word(), 1'b0);
    send_msg('1, '0, 1'b1);
    write_bit_width(65);
    send_msg(rand_word(), '0, 1'b1);
    // last message exactly completes a word
    write_bit_width(32);
    send_msg(rand_word(), rand_word(), 1'b0);
    send_msg(rand_word(), rand_word(), 1'b1);
    // last message fills a word and spills: two words
    write_bit_width(48);
    send_msg(rand_word(), rand_word(), 1'b0);
    send_msg(rand_word(), rand_word(), 1'b1);
    write_bit_width(63);
    send_msg('1, '0, 1'b0);
    send_msg('1, '0, 1'b1);
    // fields straddling word boundaries
    write_bit_width(33);
    send_msg(rand_word(), '0, 1'b0);
    send_msg(rand_word(), rand_word(), 1'b0);
    send_msg(rand_word(), rand_word(), 1'b1);
  endtask

  // Random streams across a series of widths and idling patterns
  task automatic test_random_streams();
    int unsigned                   sent;
    int unsigned                   run_len;
    logic [mmbp_pkg::WordBits-1:0] msg;
    logic [mmbp_pkg::WordBits-1:0] pad;
    bit                            zero_pad;
    bit                            drop_last;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0:       write_bit_width(1);
        1:       write_bit_width(mmbp_pkg::WordBits);
        2:       write_bit_width(0);
        3:       write_bit_width($urandom_range(65, 127));
        default: write_bit_width($urandom_range(2, 63));
      endcase
      send_idle = (phase % 4 != 1) && (phase % 4 != 3);
      recv_idle = (phase % 4 != 2) && (phase % 4 != 3);
      zero_pad  = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 90) begin
        run_len   = $urandom_range(1, 24);
        drop_last = ($urandom_range(0, 7) == 0);  // broken stream runs into the next
        for (int i = 0; i < run_len; i++) begin
          case ($urandom_range(0, 7))
            0:       msg = '0;
            1:       msg = '1;
            default: msg = rand_word();
          endcase
          pad = zero_pad ? '0 : rand_word();
          send_msg(msg, pad, (i == run_len - 1) && !drop_last);
          sent++;
        end
      end
    end
  endtask

  // Output held off while input keeps coming, then a full drain pause
  task automatic test_backpressure();
    write_bit_width(mmbp_pkg::WordBits);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_len  = HOLD_CYCLES;
    for (int i = 0; i < 40; i++)
      send_msg(rand_word(), rand_word(), i == 39);
    // sender waits for every word before the next stream
    msg_if.valid <= 1'b0;
    wait_words_done();
    recv_idle = 1'b1;
    for (int i = 0; i < 10; i++)
      send_msg(rand_word(), '0, i == 9);
  endtask

  initial begin
    errors       = 0;
    quiet_cycles = 0;
    hold_len     = 0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    width_reg    = mmbp_pkg::WidthReset;
    partial_acc  = '0;
    fill_cnt     = 0;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    msg_if.valid         <= 1'b0;
    msg_if.message_value <= '0;
    msg_if.pad_word      <= '0;
    msg_if.last_message  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_streams();
    test_backpressure();

    msg_if.valid <= 1'b0;
    wait_words_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
